// ===== src/rtc_pkg.sv =====
// Shared types and constants for the real time counter with compare channels.
package rtc_pkg;

    localparam int CHANNELS     = 4;
    localparam int COUNTER_BITS = 24;
    localparam int OVF_BITS     = 40;
    localparam int PRE_BITS     = 12;
    localparam int FUNC_W       = 3;
    localparam int CHAN_W       = 3;
    localparam int PERIOD_W     = 24;
    localparam int STATUS_W     = 2;
    localparam int EVENT_W      = 6;
    localparam int VALUE_W      = 24;
    localparam int TCOUNT_W     = 64;

    typedef enum logic [FUNC_W-1:0] {
        FUNC_TICK   = 3'd0,
        FUNC_CLEAR  = 3'd1,
        FUNC_ARM    = 3'd2,
        FUNC_DISARM = 3'd3,
        FUNC_READ   = 3'd4
    } t_func;

    typedef enum logic [STATUS_W-1:0] {
        ST_OK          = 2'd0,
        ST_BAD_CHANNEL = 2'd1,
        ST_ZERO_PERIOD = 2'd2
    } t_status;

    localparam int EV_TICK     = 0;
    localparam int EV_OVERFLOW = 1;
    localparam int EV_MATCH0   = 2;

    typedef struct packed {
        logic [FUNC_W-1:0]   func;
        logic [CHAN_W-1:0]   channel;
        logic [PERIOD_W-1:0] period_ticks;
        logic                continuous;
    } t_item;

    // counter state seen by the compare channels
    typedef struct packed {
        logic                    step;
        logic                    wrap;
        logic [COUNTER_BITS-1:0] cur;
        logic [COUNTER_BITS-1:0] nxt;
        logic [OVF_BITS-1:0]     ovf_nxt;
    } t_cnt_info;

    typedef struct packed {
        logic                    arm;
        logic                    disarm;
        logic [COUNTER_BITS-1:0] period;
        logic                    continuous;
    } t_ch_cmd;

endpackage

// ===== src/rtc_ifs.sv =====
// Valid/ready channel interfaces for items, results and the prescaler write.
interface rtc_item_if;
    logic                          valid;
    logic                          ready;
    logic [rtc_pkg::FUNC_W-1:0]    func;
    logic [rtc_pkg::CHAN_W-1:0]    channel;
    logic [rtc_pkg::PERIOD_W-1:0]  period_ticks;
    logic                          continuous;
    modport source (output valid, func, channel, period_ticks, continuous, input ready);
    modport sink   (input valid, func, channel, period_ticks, continuous, output ready);
endinterface

interface rtc_result_if;
    logic                          valid;
    logic                          ready;
    logic [rtc_pkg::STATUS_W-1:0]  status;
    logic [rtc_pkg::EVENT_W-1:0]   event_flags;
    logic [rtc_pkg::VALUE_W-1:0]   counter_value;
    logic [rtc_pkg::TCOUNT_W-1:0]  tick_count;
    modport source (output valid, status, event_flags, counter_value, tick_count, input ready);
    modport sink   (input valid, status, event_flags, counter_value, tick_count, output ready);
endinterface

interface rtc_cfg_if;
    logic                          valid;
    logic                          ready;
    logic [rtc_pkg::PRE_BITS-1:0]  prescale_minus_one;
    modport source (output valid, prescale_minus_one, input ready);
    modport sink   (input valid, prescale_minus_one, output ready);
endinterface

// ===== src/rtc_compare_timer.sv =====
// Top level: input register, counter and compare channels, result register.
// One item is taken per clock cycle while results are taken. Its result word
// is valid once the item has passed through the input register and the result
// register captures it. While a result waits to be taken, one more item can
// enter the input register; after that the input stalls until the result is
// taken. The sustained rate of one item per cycle is set by the counter and
// channel state, which update in the cycle an item leaves the input register.
// Prescaler writes take effect once registered, including on a tick word already
// in the input register, so write the prescaler only while no words are in flight.
module rtc_compare_timer (
    input  logic        i_clk,
    input  logic        i_rst_n,
    rtc_item_if.sink    i_item,
    rtc_cfg_if.sink     i_cfg,
    rtc_result_if.source o_result
);
    rtc_pkg::t_item       r_item;
    logic                 r_v1;
    logic                 r_v2;
    logic                 adv2;
    logic                 fire;
    rtc_pkg::t_func       func;
    rtc_pkg::t_cnt_info   cnt;
    rtc_pkg::t_ch_cmd     cmd [rtc_pkg::CHANNELS];
    logic [rtc_pkg::CHANNELS-1:0] match;
    logic                 bad_ch;
    rtc_pkg::t_status     status;
    logic [rtc_pkg::EVENT_W-1:0] events;

    assign adv2         = !r_v2 || o_result.ready;
    assign fire         = r_v1 && adv2;
    assign i_item.ready = !r_v1 || adv2;
    assign func         = rtc_pkg::t_func'(r_item.func);
    assign bad_ch       = r_item.channel >= rtc_pkg::CHAN_W'(rtc_pkg::CHANNELS);

    always_comb begin
        status = rtc_pkg::ST_OK;
        case (func)
            rtc_pkg::FUNC_ARM: begin
                if (bad_ch) begin
                    status = rtc_pkg::ST_BAD_CHANNEL;
                end else if (r_item.period_ticks == '0) begin
                    status = rtc_pkg::ST_ZERO_PERIOD;
                end
            end
            rtc_pkg::FUNC_DISARM: begin
                if (bad_ch) begin
                    status = rtc_pkg::ST_BAD_CHANNEL;
                end
            end
            default: status = rtc_pkg::ST_OK;
        endcase
    end

    always_comb begin
        events = '0;
        events[rtc_pkg::EV_TICK]     = cnt.step;
        events[rtc_pkg::EV_OVERFLOW] = cnt.wrap;
        for (int i = 0; i < rtc_pkg::CHANNELS; i++) begin
            events[rtc_pkg::EV_MATCH0 + i] = match[i];
        end
    end

    rtc_counter u_counter (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_cfg   (i_cfg),
        .i_fire  (fire),
        .i_func  (func),
        .o_info  (cnt)
    );

    for (genvar g = 0; g < rtc_pkg::CHANNELS; g++) begin : g_ch
        logic sel;
        assign sel = fire && (r_item.channel == rtc_pkg::CHAN_W'(g));
        assign cmd[g].arm        = sel && (func == rtc_pkg::FUNC_ARM)
                                   && (status == rtc_pkg::ST_OK);
        assign cmd[g].disarm     = sel && (func == rtc_pkg::FUNC_DISARM);
        assign cmd[g].period     = rtc_pkg::COUNTER_BITS'(r_item.period_ticks);
        assign cmd[g].continuous = r_item.continuous;

        rtc_compare_ch u_ch (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_cmd   (cmd[g]),
            .i_cnt   (cnt),
            .o_match (match[g])
        );
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            if (i_item.valid && i_item.ready) begin
                r_v1 <= 1'b1;
            end else if (fire) begin
                r_v1 <= 1'b0;
            end
            if (fire) begin
                r_v2 <= 1'b1;
            end else if (o_result.ready) begin
                r_v2 <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_item.valid && i_item.ready) begin
            r_item.func         <= i_item.func;
            r_item.channel      <= i_item.channel;
            r_item.period_ticks <= i_item.period_ticks;
            r_item.continuous   <= i_item.continuous;
        end
        if (fire) begin
            o_result.status        <= status;
            o_result.event_flags   <= events;
            o_result.counter_value <= rtc_pkg::VALUE_W'(cnt.nxt);
            o_result.tick_count    <= (rtc_pkg::TCOUNT_W'(cnt.ovf_nxt) << rtc_pkg::COUNTER_BITS)
                                      | rtc_pkg::TCOUNT_W'(cnt.nxt);
        end
    end

    assign o_result.valid = r_v2;
endmodule

// ===== src/rtc_counter.sv =====
// Prescaler register, prescale counter, main counter and overflow count.
module rtc_counter (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    rtc_cfg_if.sink              i_cfg,
    input  logic                 i_fire,
    input  rtc_pkg::t_func       i_func,
    output rtc_pkg::t_cnt_info   o_info
);
    logic [rtc_pkg::PRE_BITS-1:0]     r_presc;
    logic [rtc_pkg::PRE_BITS-1:0]     r_pre;
    logic [rtc_pkg::PRE_BITS-1:0]     n_pre;
    logic [rtc_pkg::COUNTER_BITS-1:0] r_cnt;
    logic [rtc_pkg::COUNTER_BITS-1:0] cnt_inc;
    logic [rtc_pkg::OVF_BITS-1:0]     r_ovf;
    logic                             tick;
    logic                             clear;

    assign i_cfg.ready = 1'b1;

    always_comb begin
        tick    = i_fire && (i_func == rtc_pkg::FUNC_TICK);
        clear   = i_fire && (i_func == rtc_pkg::FUNC_CLEAR);
        cnt_inc = r_cnt + 1'b1;

        o_info.step = tick && (r_pre >= r_presc);
        o_info.wrap = o_info.step && (cnt_inc == '0);
        o_info.cur  = r_cnt;
        if (clear) begin
            o_info.nxt = '0;
        end else if (o_info.step) begin
            o_info.nxt = cnt_inc;
        end else begin
            o_info.nxt = r_cnt;
        end
        o_info.ovf_nxt = o_info.wrap ? r_ovf + 1'b1 : r_ovf;

        if (clear || o_info.step) begin
            n_pre = '0;
        end else if (tick) begin
            n_pre = r_pre + 1'b1;
        end else begin
            n_pre = r_pre;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_presc <= '0;
            r_pre   <= '0;
            r_cnt   <= '0;
            r_ovf   <= '0;
        end else begin
            if (i_cfg.valid) begin
                r_presc <= i_cfg.prescale_minus_one;
            end
            if (i_fire) begin
                r_pre <= n_pre;
                r_cnt <= o_info.nxt;
                r_ovf <= o_info.ovf_nxt;
            end
        end
    end
endmodule

// ===== src/rtc_compare_ch.sv =====
// One compare channel: compare value, period, armed and continuous flags.
module rtc_compare_ch (
    input  logic                 i_clk,
    input  logic                 i_rst_n,
    input  rtc_pkg::t_ch_cmd     i_cmd,
    input  rtc_pkg::t_cnt_info   i_cnt,
    output logic                 o_match
);
    logic [rtc_pkg::COUNTER_BITS-1:0] r_cmp;
    logic [rtc_pkg::COUNTER_BITS-1:0] r_per;
    logic                             r_armed;
    logic                             r_cont;

    assign o_match = i_cnt.step && r_armed && (r_cmp == i_cnt.nxt);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_cmp   <= '0;
            r_per   <= '0;
            r_armed <= 1'b0;
            r_cont  <= 1'b0;
        end else if (i_cmd.disarm) begin
            r_cmp   <= '0;
            r_per   <= '0;
            r_armed <= 1'b0;
            r_cont  <= 1'b0;
        end else if (i_cmd.arm) begin
            r_cmp   <= i_cnt.cur + i_cmd.period;
            r_per   <= i_cmd.period;
            r_armed <= 1'b1;
            r_cont  <= i_cmd.continuous;
        end else if (o_match && r_cont) begin
            r_cmp   <= i_cnt.nxt + r_per;
        end
    end
endmodule

// ===== src/rtc_checker.sv =====
// Port-level assertions for the real time counter, bound to the top level.
module rtc_checker (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_out_valid,
    input  logic                          i_out_ready,
    input  logic [rtc_pkg::STATUS_W-1:0]  i_status,
    input  logic [rtc_pkg::EVENT_W-1:0]   i_events,
    input  logic [rtc_pkg::VALUE_W-1:0]   i_value
);
    a_out_hold: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && !i_out_ready |=> i_out_valid)
        else $error("result word dropped while stalled");

    a_status_quiet: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_status != '0) |-> (i_events == '0))
        else $error("events flagged on a failed command");

    a_events_need_tick: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && (i_events[rtc_pkg::EVENT_W-1:rtc_pkg::EV_OVERFLOW] != '0)
        |-> i_events[rtc_pkg::EV_TICK])
        else $error("overflow or match without a counter step");

    a_wrap_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_out_valid && i_events[rtc_pkg::EV_OVERFLOW] |-> (i_value == '0))
        else $error("overflow with nonzero counter");
endmodule

bind rtc_compare_timer rtc_checker u_rtc_checker (
    .i_clk       (i_clk),
    .i_rst_n     (i_rst_n),
    .i_out_valid (o_result.valid),
    .i_out_ready (o_result.ready),
    .i_status    (o_result.status),
    .i_events    (o_result.event_flags),
    .i_value     (o_result.counter_value)
);
